// File: sv/wnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnf_pkg
// Shared constants and types for the weekly alarm next-fire pipeline.
// ----------------------------------------------------------------------------
package wnf_pkg;

    localparam int unsigned SecondsPerDay = 86400;
    localparam int unsigned MsPerSecond   = 1000;
    localparam int unsigned DaysPerWeek   = 7;

    // x / 1000 for 32-bit x: (x * Recip1000) >> Shift1000, exact over full range
    localparam logic [28:0] Recip1000 = 29'd274877907;
    localparam int unsigned Shift1000 = 38;
    // y / 675 for 25-bit y (86400 = 128 * 675)
    localparam logic [25:0] Recip675  = 26'd50903317;
    localparam int unsigned Shift675  = 35;
    // z / 7 for 16-bit z
    localparam logic [16:0] Recip7    = 17'd74899;
    localparam int unsigned Shift7    = 19;

    typedef enum logic [1:0] {
        CFG_START_WEEKDAY = 2'd0,
        CFG_START_SOD     = 2'd1,
        CFG_START_MILLIS  = 2'd2,
        CFG_START_EPOCH   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [16:0] sod;
        logic [31:0] millis;
        logic [31:0] epoch;
    } t_cfg;

    // hand-off from time split to fire calculation
    typedef struct packed {
        logic        valid;
        logic        one_shot;
        logic [31:0] now_ms;
        logic [6:0]  mask;
        logic [31:0] alarm;
        logic [31:0] os_secs;   // alarm - start epoch
        logic [16:0] daytime;
        logic [2:0]  wd;
        logic        passed;
    } t_split;

endpackage

// File: sv/weekly_alarm_next_fire.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_alarm_next_fire
// Next firing time of a weekday-repeating or one-shot alarm, in ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_now_ms, i_repeat_mask and i_alarm_time with
//   start high; a transaction is taken at every edge where start is high and
//   busy is low. busy is always low: the pipeline takes one transaction per
//   clock cycle, every cycle.
//   Result channel: o_fire_ms is shown for one cycle with o_fire_valid high,
//   once the transaction has passed all ten pipeline registers; results
//   leave in order. The receiver cannot stall, so nothing is ever held back.
//   Config channel: i_cfg_valid/o_cfg_ready with register index and data;
//   o_cfg_ready is always high. Write only while the pipeline is empty.
//   Reset (i_rst_n low, synchronous) clears all valid bits and sets the start
//   reference to weekday 1, second 0, ms 0, epoch 0.
//   Latency is set by the three reciprocal multipliers (ms to s, s to days,
//   days mod 7) and the final seconds-to-ms multiply, each with its own stage.
// ----------------------------------------------------------------------------
module weekly_alarm_next_fire (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_now_ms,
    input  logic [6:0]  i_repeat_mask,
    input  logic [31:0] i_alarm_time,
    // result channel
    output logic        o_fire_valid,
    output logic [31:0] o_fire_ms,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import wnf_pkg::*;

    t_cfg   w_cfg;
    t_split w_split;
    logic   w_accept;

    // fully pipelined, never stalls
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    wnf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // stages 1-6: time of day and weekday
    wnf_time_split u_split (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_now_ms      (i_now_ms),
        .i_repeat_mask (i_repeat_mask),
        .i_alarm_time  (i_alarm_time),
        .i_cfg         (w_cfg),
        .o_split       (w_split)
    );

    // stages 7-10: day search and ms conversion
    wnf_fire_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_split   (w_split),
        .i_cfg     (w_cfg),
        .o_valid   (o_fire_valid),
        .o_fire_ms (o_fire_ms)
    );

endmodule

// File: sv/wnf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnf_cfg_regs
// Start-reference register file behind the configuration write channel.
// ----------------------------------------------------------------------------
module wnf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output wnf_pkg::t_cfg o_cfg
);
    import wnf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weekday <= 3'd1;
            r_cfg.sod     <= '0;
            r_cfg.millis  <= '0;
            r_cfg.epoch   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_WEEKDAY: r_cfg.weekday <= i_cfg_data[2:0];
                CFG_START_SOD:     r_cfg.sod     <= i_cfg_data[16:0];
                CFG_START_MILLIS:  r_cfg.millis  <= i_cfg_data;
                CFG_START_EPOCH:   r_cfg.epoch   <= i_cfg_data;
                default:           r_cfg.epoch   <= r_cfg.epoch;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/wnf_time_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnf_time_split
// Six stages: elapsed ms, elapsed seconds, seconds total, day count, second
// of day, then the weekday index together with the alarm-passed flag.
// ----------------------------------------------------------------------------
module wnf_time_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_now_ms,
    input  logic [6:0]      i_repeat_mask,
    input  logic [31:0]     i_alarm_time,
    input  wnf_pkg::t_cfg   i_cfg,
    output wnf_pkg::t_split o_split
);
    import wnf_pkg::*;

    typedef struct packed {
        logic        one_shot;
        logic [31:0] now_ms;
        logic [6:0]  mask;
        logic [31:0] alarm;
        logic [31:0] os_secs;
    } t_carry;

    // valid bits
    logic [4:0] r_v;
    t_carry r_c1, r_c2, r_c3, r_c4, r_c5;

    logic [31:0] r_diff;                       // S1
    logic [22:0] r_esec;                       // S2
    logic [31:0] r_total3;                     // S3
    logic [31:0] r_total4;  logic [15:0] r_days4;  // S4
    logic [15:0] r_days5;   logic [16:0] r_daytime5;
    logic [12:0] r_q7;                         // S5
    t_split      r_out;                        // S6

    logic [60:0] n_prod1;
    logic [50:0] n_prod2;
    logic [32:0] n_dayms;
    logic [32:0] n_prod7;
    logic [15:0] n_q7x7;
    logic [2:0]  n_dmod7;
    logic [2:0]  n_swmod;
    logic [4:0]  n_sum;
    logic [2:0]  n_wd;

    always_comb begin
        n_prod1 = 61'(r_diff) * 61'(Recip1000);
        n_prod2 = 51'(r_total3[31:7]) * 51'(Recip675);
        n_dayms = 33'(r_days4) * 33'(SecondsPerDay);
        n_prod7 = 33'(r_days4) * 33'(Recip7);
        n_q7x7  = 16'(r_q7) * 16'(DaysPerWeek);
        n_dmod7 = 3'(r_days5 - n_q7x7);
        n_swmod = (i_cfg.weekday == 3'(DaysPerWeek)) ? 3'd0 : i_cfg.weekday;
        n_sum   = 5'(n_swmod) + 5'(n_dmod7) + 5'(DaysPerWeek - 1);
        if (n_sum >= 5'(2 * DaysPerWeek)) begin
            n_wd = 3'(n_sum - 5'(2 * DaysPerWeek));
        end else if (n_sum >= 5'(DaysPerWeek)) begin
            n_wd = 3'(n_sum - 5'(DaysPerWeek));
        end else begin
            n_wd = 3'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out.valid <= 1'b0;
        end else begin
            r_v         <= {r_v[3:0], i_valid};
            r_out.valid <= r_v[4];
        end

        // S1
        r_c1.one_shot <= (i_repeat_mask == 7'd0);
        r_c1.now_ms   <= i_now_ms;
        r_c1.mask     <= i_repeat_mask;
        r_c1.alarm    <= i_alarm_time;
        r_c1.os_secs  <= i_alarm_time - i_cfg.epoch;
        r_diff        <= i_now_ms - i_cfg.millis;
        // S2
        r_c2   <= r_c1;
        r_esec <= 23'(n_prod1 >> Shift1000);
        // S3
        r_c3     <= r_c2;
        r_total3 <= 32'(i_cfg.sod) + 32'(r_esec);
        // S4
        r_c4     <= r_c3;
        r_total4 <= r_total3;
        r_days4  <= 16'(n_prod2 >> Shift675);
        // S5
        r_c5       <= r_c4;
        r_days5    <= r_days4;
        r_daytime5 <= 17'(r_total4 - n_dayms[31:0]);
        r_q7       <= 13'(n_prod7 >> Shift7);
        // S6
        r_out.one_shot <= r_c5.one_shot;
        r_out.now_ms   <= r_c5.now_ms;
        r_out.mask     <= r_c5.mask;
        r_out.alarm    <= r_c5.alarm;
        r_out.os_secs  <= r_c5.os_secs;
        r_out.daytime  <= r_daytime5;
        r_out.wd       <= n_wd;
        r_out.passed   <= (r_c5.alarm < 32'(r_daytime5));
    end

    assign o_split = r_out;

endmodule

// File: sv/wnf_fire_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnf_fire_calc
// Four stages: day-offset search, offset seconds, scale to ms, final add.
// ----------------------------------------------------------------------------
module wnf_fire_calc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wnf_pkg::t_split i_split,
    input  wnf_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    output logic [31:0]     o_fire_ms
);
    import wnf_pkg::*;

    logic [2:0]  r_v;
    // S7
    logic        r_os7;
    logic [31:0] r_now7, r_ossec7, r_base7;
    logic [3:0]  r_off7;
    // S8
    logic        r_os8;
    logic [31:0] r_now8, r_secs8;
    // one-shot seconds follow the S8 timing
    logic [31:0] r_ossec7_d;
    // S9
    logic [31:0] r_prod9, r_add9;
    // S10
    logic        r_valid;
    logic [31:0] r_fire;

    logic [13:0] n_dbl;
    logic [6:0]  n_rot;
    logic [3:0]  n_off;
    logic [31:0] n_mul_in;
    logic [41:0] n_prod;

    always_comb begin
        n_dbl = {i_split.mask, i_split.mask};
        n_rot = 7'(n_dbl >> i_split.wd);
        n_off = 4'(DaysPerWeek);
        for (int k = 6; k >= 1; k--) begin
            if (n_rot[k]) begin
                n_off = 4'(k);
            end
        end
        if (n_rot[0] && !i_split.passed) begin
            n_off = 4'd0;
        end
        n_mul_in = r_os8 ? r_ossec7_d : r_secs8;
        n_prod   = 42'(n_mul_in) * 42'(MsPerSecond);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[1:0], i_split.valid};
            r_valid <= r_v[2];
        end
        // S7
        r_os7    <= i_split.one_shot;
        r_now7   <= i_split.now_ms;
        r_ossec7 <= i_split.os_secs;
        r_base7  <= i_split.alarm - 32'(i_split.daytime);
        r_off7   <= n_off;
        // S8
        r_os8      <= r_os7;
        r_now8     <= r_now7;
        r_ossec7_d <= r_ossec7;
        r_secs8    <= 32'(r_off7) * 32'(SecondsPerDay) + r_base7;
        // S9
        r_prod9 <= n_prod[31:0];
        r_add9  <= r_os8 ? i_cfg.millis : r_now8 + 32'd1;
        // S10
        r_fire <= r_prod9 + r_add9;
    end

    assign o_valid   = r_valid;
    assign o_fire_ms = r_fire;

endmodule
